// File: design/pps_pkg.sv
// Package for the path progress scorer: sizes, op codes, controller states
// and the command/status structs shared by the controller and the datapath.
// No dependencies.
package pps_pkg;

   // Path storage and coordinate sizes.
   localparam int MAX_PATH_POINTS = 1024;
   localparam int COORD_BITS      = 24;
   localparam int ADDR_W          = $clog2(MAX_PATH_POINTS);
   localparam int INDEX_W         = $clog2(MAX_PATH_POINTS + 1);
   localparam int POINT_W         = 2 * COORD_BITS;

   // Distance arithmetic: absolute differences, squares and their sum.
   localparam int DIFF_W = COORD_BITS + 1;
   localparam int SQ_W   = 2 * DIFF_W;
   localparam int SUM_W  = SQ_W + 1;

   // Score arithmetic.
   localparam int WINDOW_W   = 16;
   localparam int FRAC_BITS  = 16;
   localparam int SCORE_W    = 27;
   localparam int STEP_W     = INDEX_W + 1;
   localparam int NUM_W      = ((WINDOW_W > STEP_W) ? WINDOW_W : STEP_W) + 2;
   localparam int DIVD_W     = NUM_W + FRAC_BITS;
   localparam int DIVCNT_W   = $clog2(DIVD_W + 1);
   localparam logic [WINDOW_W-1:0] WINDOW_RESET = WINDOW_W'(100);

   // Configuration port.
   localparam int DATA_W  = 32;
   localparam int PADDR_W = 3;
   localparam logic CSR_WINDOW_INDEX = 1'b0;

   // Input op codes.
   localparam int OP_W = 2;
   localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
   localparam logic [OP_W-1:0] OP_APPEND = 2'd1;
   localparam logic [OP_W-1:0] OP_SCORE  = 2'd2;

   // Controller states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DIVIDE
   } pps_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic clear;
      logic append;
      logic score_start;
      logic div_start;
      logic load_result;
   } pps_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic scan_busy;
      logic div_busy;
      logic out_free;
   } pps_status_type;

endpackage

// File: design/pps_if.sv
// Handshake channel interfaces for the path progress scorer.
// Depends on pps_pkg for field widths.
interface pps_req_if;
   import pps_pkg::*;

   logic                         valid;
   logic                         ready;
   logic [OP_W-1:0]              op;
   logic signed [COORD_BITS-1:0] first_x;
   logic signed [COORD_BITS-1:0] first_y;
   logic signed [COORD_BITS-1:0] last_x;
   logic signed [COORD_BITS-1:0] last_y;

   modport source (output valid, op, first_x, first_y, last_x, last_y, input ready);
   modport sink   (input valid, op, first_x, first_y, last_x, last_y, output ready);
endinterface

interface pps_rsp_if;
   import pps_pkg::*;

   logic                      valid;
   logic                      ready;
   logic [SCORE_W-1:0]        score;
   logic [INDEX_W-1:0]        start_index;
   logic [INDEX_W-1:0]        end_index;
   logic signed [INDEX_W-1:0] index_step;

   modport source (output valid, score, start_index, end_index, index_step, input ready);
   modport sink   (input valid, score, start_index, end_index, index_step, output ready);
endinterface

// File: design/pps_ctrl.sv
// Controller state machine of the path progress scorer.
// Depends on pps_pkg; drives the datapath through pps_cmd_type.
module pps_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic [pps_pkg::OP_W-1:0]    req_op,
   output logic                        req_ready,
   input  pps_pkg::pps_status_type     status,
   output pps_pkg::pps_cmd_type        cmd
);
   import pps_pkg::*;

   pps_state_type state_ff;
   pps_state_type state_in;
   logic          req_xfer;

   assign req_xfer = req_valid && req_ready;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer && req_op == OP_SCORE) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (!status.scan_busy) begin
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (!status.div_busy && status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Outputs: ready in idle, one-cycle commands to the datapath.
   always_comb begin
      req_ready = 1'b0;
      cmd       = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready       = 1'b1;
            cmd.clear       = req_xfer && req_op == OP_CLEAR;
            cmd.append      = req_xfer && req_op == OP_APPEND;
            cmd.score_start = req_xfer && req_op == OP_SCORE;
         end
         ST_SCAN: begin
            cmd.div_start = !status.scan_busy;
         end
         ST_DIVIDE: begin
            cmd.load_result = !status.div_busy && status.out_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

endmodule

// File: design/pps_datapath.sv
// Datapath of the path progress scorer: path memory, nearest point scan,
// restoring divider and result register. Depends on pps_pkg and pps_if.
module pps_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  pps_pkg::pps_cmd_type                cmd,
   output pps_pkg::pps_status_type             status,
   input  logic [pps_pkg::WINDOW_W-1:0]        window_poses,
   input  logic signed [pps_pkg::COORD_BITS-1:0] first_x,
   input  logic signed [pps_pkg::COORD_BITS-1:0] first_y,
   input  logic signed [pps_pkg::COORD_BITS-1:0] last_x,
   input  logic signed [pps_pkg::COORD_BITS-1:0] last_y,
   pps_rsp_if.source                           rsp
);
   import pps_pkg::*;

   // Absolute difference of two signed coordinates.
   function automatic logic [DIFF_W-1:0] abs_diff(input logic signed [COORD_BITS-1:0] a,
                                                  input logic signed [COORD_BITS-1:0] b);
      logic signed [DIFF_W-1:0] d;
      d = DIFF_W'(a) - DIFF_W'(b);
      return d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
   endfunction

   // Path memory and fill count.
   logic [POINT_W-1:0] path_mem [MAX_PATH_POINTS];
   logic [INDEX_W-1:0] count_ff;

   // Scan pipeline.
   logic [INDEX_W-1:0]          scan_idx_ff;
   logic                        scan_active_ff;
   logic signed [COORD_BITS-1:0] tgt_sx_ff, tgt_sy_ff, tgt_ex_ff, tgt_ey_ff;
   logic [POINT_W-1:0]          rd_data_ff;
   logic                        v1_ff, v2_ff, v3_ff, v4_ff;
   logic [INDEX_W-1:0]          idx1_ff, idx2_ff, idx3_ff, idx4_ff;
   logic [DIFF_W-1:0]           dsx_ff, dsy_ff, dex_ff, dey_ff;
   logic [SQ_W-1:0]             qsx_ff, qsy_ff, qex_ff, qey_ff;
   logic [SUM_W-1:0]            sum_s_ff, sum_e_ff;
   logic                        have_ff;
   logic [SUM_W-1:0]            best_s_sum_ff, best_e_sum_ff;
   logic [INDEX_W-1:0]          best_s_idx_ff, best_e_idx_ff;

   // Divider.
   logic                        div_busy_ff;
   logic [DIVCNT_W-1:0]         div_cnt_ff;
   logic [DIVD_W-1:0]           divd_ff;
   logic [WINDOW_W-1:0]         rem_ff;
   logic                        zero_ff;
   logic signed [STEP_W-1:0]    step_ff;
   logic signed [STEP_W-1:0]    step_in;
   logic signed [NUM_W-1:0]     step_ext;
   logic signed [NUM_W-1:0]     win_ext;
   logic [NUM_W-1:0]            num_in;
   logic                        zero_in;
   logic [WINDOW_W:0]           rem_shift;
   logic                        qbit;
   logic [SCORE_W-1:0]          score_in;

   // Result register.
   logic                        rsp_valid_ff;
   logic [SCORE_W-1:0]          score_ff;
   logic [INDEX_W-1:0]          start_idx_ff, end_idx_ff;

   // Path storage: clear resets the count, append writes at the count.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.clear) begin
         count_ff <= '0;
      end else if (cmd.append && count_ff < INDEX_W'(MAX_PATH_POINTS)) begin
         count_ff <= count_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.append && count_ff < INDEX_W'(MAX_PATH_POINTS)) begin
         path_mem[count_ff[ADDR_W-1:0]] <= {first_x, first_y};
      end
   end

   // Memory read port for the scan.
   always_ff @(posedge clock) begin
      rd_data_ff <= path_mem[scan_idx_ff[ADDR_W-1:0]];
   end

   // Scan address counter: one stored point is read per cycle.
   always_ff @(posedge clock) begin
      if (reset) begin
         scan_active_ff <= 1'b0;
         v1_ff          <= 1'b0;
         v2_ff          <= 1'b0;
         v3_ff          <= 1'b0;
         v4_ff          <= 1'b0;
      end else begin
         if (cmd.score_start) begin
            scan_active_ff <= 1'b1;
         end else if (scan_active_ff && scan_idx_ff >= count_ff) begin
            scan_active_ff <= 1'b0;
         end
         v1_ff <= scan_active_ff && scan_idx_ff < count_ff;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.score_start) begin
         scan_idx_ff <= '0;
         tgt_sx_ff   <= first_x;
         tgt_sy_ff   <= first_y;
         tgt_ex_ff   <= last_x;
         tgt_ey_ff   <= last_y;
      end else if (scan_active_ff && scan_idx_ff < count_ff) begin
         scan_idx_ff <= scan_idx_ff + 1'b1;
      end
      idx1_ff <= scan_idx_ff;
      idx2_ff <= idx1_ff;
      idx3_ff <= idx2_ff;
      idx4_ff <= idx3_ff;
   end

   // Distance stages: differences, squares, sums.
   always_ff @(posedge clock) begin
      dsx_ff   <= abs_diff(tgt_sx_ff, rd_data_ff[POINT_W-1:COORD_BITS]);
      dsy_ff   <= abs_diff(tgt_sy_ff, rd_data_ff[COORD_BITS-1:0]);
      dex_ff   <= abs_diff(tgt_ex_ff, rd_data_ff[POINT_W-1:COORD_BITS]);
      dey_ff   <= abs_diff(tgt_ey_ff, rd_data_ff[COORD_BITS-1:0]);
      qsx_ff   <= dsx_ff * dsx_ff;
      qsy_ff   <= dsy_ff * dsy_ff;
      qex_ff   <= dex_ff * dex_ff;
      qey_ff   <= dey_ff * dey_ff;
      sum_s_ff <= SUM_W'(qsx_ff) + SUM_W'(qsy_ff);
      sum_e_ff <= SUM_W'(qex_ff) + SUM_W'(qey_ff);
   end

   // Running minimum; a strict compare keeps the first point on ties.
   always_ff @(posedge clock) begin
      if (reset) begin
         have_ff <= 1'b0;
      end else if (cmd.score_start) begin
         have_ff <= 1'b0;
      end else if (v4_ff) begin
         have_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.score_start) begin
         best_s_idx_ff <= count_ff;
         best_e_idx_ff <= count_ff;
      end else if (v4_ff) begin
         if (!have_ff || sum_s_ff < best_s_sum_ff) begin
            best_s_sum_ff <= sum_s_ff;
            best_s_idx_ff <= idx4_ff;
         end
         if (!have_ff || sum_e_ff < best_e_sum_ff) begin
            best_e_sum_ff <= sum_e_ff;
            best_e_idx_ff <= idx4_ff;
         end
      end
   end

   // Divider setup: step, out-of-window test and dividend.
   always_comb begin
      step_in  = STEP_W'(signed'({1'b0, best_e_idx_ff})) -
                 STEP_W'(signed'({1'b0, best_s_idx_ff}));
      step_ext = NUM_W'(step_in);
      win_ext  = NUM_W'(signed'({1'b0, window_poses}));
      zero_in  = (window_poses == '0) || (step_ext > win_ext);
      num_in   = NUM_W'(win_ext - step_ext);
   end

   // One quotient bit per cycle, restoring division.
   always_comb begin
      rem_shift = {rem_ff, divd_ff[DIVD_W-1]};
      qbit      = rem_shift >= {1'b0, window_poses};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         div_busy_ff <= 1'b0;
      end else if (cmd.div_start) begin
         div_busy_ff <= 1'b1;
      end else if (div_busy_ff && div_cnt_ff == DIVCNT_W'(DIVD_W - 1)) begin
         div_busy_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         div_cnt_ff <= '0;
         divd_ff    <= {num_in, FRAC_BITS'(0)};
         rem_ff     <= '0;
         zero_ff    <= zero_in;
         step_ff    <= step_in;
      end else if (div_busy_ff) begin
         div_cnt_ff <= div_cnt_ff + 1'b1;
         divd_ff    <= {divd_ff[DIVD_W-2:0], qbit};
         rem_ff     <= qbit ? WINDOW_W'(rem_shift - {1'b0, window_poses})
                            : rem_shift[WINDOW_W-1:0];
      end
   end

   // Final score: zero outside the window, saturated if too wide.
   always_comb begin
      if (zero_ff) begin
         score_in = '0;
      end else if (divd_ff[DIVD_W-1:SCORE_W] != '0) begin
         score_in = '1;
      end else begin
         score_in = divd_ff[SCORE_W-1:0];
      end
   end

   // Result register; it frees as soon as the sink takes the transfer.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_result) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_result) begin
         score_ff     <= score_in;
         start_idx_ff <= best_s_idx_ff;
         end_idx_ff   <= best_e_idx_ff;
      end
   end

   logic signed [INDEX_W-1:0] out_step_ff;
   always_ff @(posedge clock) begin
      if (cmd.load_result) begin
         out_step_ff <= step_ff[INDEX_W-1:0];
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.score       = score_ff;
   assign rsp.start_index = start_idx_ff;
   assign rsp.end_index   = end_idx_ff;
   assign rsp.index_step  = out_step_ff;

   // Status to the controller.
   assign status.scan_busy = scan_active_ff || v1_ff || v2_ff || v3_ff || v4_ff;
   assign status.div_busy  = div_busy_ff;
   assign status.out_free  = !rsp_valid_ff || rsp.ready;

endmodule

// File: design/path_progress_scorer_top.sv
// Top level of the path progress scorer: configuration register and the
// controller/datapath pair. Depends on pps_pkg, pps_if, pps_ctrl, pps_datapath.
//
//   Port group   Direction   Handshake              Contents
//   req          in          valid/ready            op, first_x/y, last_x/y
//   rsp          out         valid/ready            score, start/end index, step
//   psel/...     in          APB write, pready=1    window_poses at address 0
//
// Clear and append items give no transfer on rsp. A score item holds the input
// for one pass over the path memory at one read per cycle through a pipeline of
// five stages, the start of the divider, one quotient bit per cycle for 34 bits
// and the load of the result. The next item is accepted once the score leaves
// the divider. Reset is synchronous; it empties the path and sets the window to
// 100. A stalled rsp holds its result while the next item is already taken; a
// score that finishes while the result register is still full waits.
module path_progress_scorer_top (
   input  logic                          clock,
   input  logic                          reset,
   pps_req_if.sink                       req,
   pps_rsp_if.source                     rsp,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [pps_pkg::PADDR_W-1:0]   paddr,
   input  logic [pps_pkg::DATA_W-1:0]    pwdata,
   output logic [pps_pkg::DATA_W-1:0]    prdata,
   output logic                          pready
);
   import pps_pkg::*;

   logic [WINDOW_W-1:0] window_poses_ff;
   logic                csr_write;
   logic                req_ready;
   pps_cmd_type         cmd;
   pps_status_type      status;

   // Configuration register.
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_poses_ff <= WINDOW_RESET;
      end else if (csr_write && paddr[PADDR_W-1] == CSR_WINDOW_INDEX) begin
         window_poses_ff <= pwdata[WINDOW_W-1:0];
      end
   end

   // Register readback.
   always_comb begin
      if (paddr[PADDR_W-1] == CSR_WINDOW_INDEX) begin
         prdata = DATA_W'(window_poses_ff);
      end else begin
         prdata = '0;
      end
   end

   assign req.ready = req_ready;

   pps_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_op    (req.op),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   pps_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .window_poses (window_poses_ff),
      .first_x      (req.first_x),
      .first_y      (req.first_y),
      .last_x       (req.last_x),
      .last_y       (req.last_y),
      .rsp          (rsp)
   );

endmodule

// File: tb/path_progress_scorer_top_tb.sv
// Self-checking testbench for path_progress_scorer_top: directed and random traffic
// with an in-bench path/score predictor and APB window writes between phases.
// Depends on pps_pkg, pps_if and the RTL of the path progress scorer.
module path_progress_scorer_top_tb;
   import pps_pkg::*;

   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
   localparam logic [PADDR_W-1:0] WINDOW_ADDR = PADDR_W'(4 * int'(CSR_WINDOW_INDEX));
   localparam logic signed [COORD_BITS-1:0] COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
   localparam logic signed [COORD_BITS-1:0] COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};
   localparam longint SCORE_MAX = (longint'(1) << SCORE_W) - 1;
   localparam int SETTLE_CYCLES = 50;
   localparam int IDLE_LIMIT = 20000;

   typedef struct packed {
      logic [SCORE_W-1:0]        score;
      logic [INDEX_W-1:0]        start_index;
      logic [INDEX_W-1:0]        end_index;
      logic signed [INDEX_W-1:0] index_step;
   } score_result_type;

   typedef enum logic [1:0] {
      RDY_ALWAYS,
      RDY_COIN,
      RDY_RUNS
   } ready_mode_type;

   // Predicts each score from its own copy of the path and window, and holds the
   // scores still owed by the block in transfer order.
   class progress_tracker;
      logic signed [COORD_BITS-1:0] path_x [MAX_PATH_POINTS];
      logic signed [COORD_BITS-1:0] path_y [MAX_PATH_POINTS];
      int unsigned path_len;
      logic [WINDOW_W-1:0] window_len;
      score_result_type pending_scores [$];
      int unsigned mismatches;

      function new();
         path_len = 0;
         window_len = WINDOW_RESET;
         mismatches = 0;
      endfunction

      function void set_window(logic [WINDOW_W-1:0] value);
         window_len = value;
      endfunction

      function int unsigned pending();
         return pending_scores.size();
      endfunction

      // Nearest stored point by squared distance; the lowest index wins a tie.
      // An empty path yields the count itself.
      function logic [INDEX_W-1:0] nearest_point(logic signed [COORD_BITS-1:0] qx,
                                                 logic signed [COORD_BITS-1:0] qy);
         longint dx;
         longint dy;
         longint sq_dist;
         longint best_dist;
         logic [INDEX_W-1:0] best;
         best = INDEX_W'(path_len);
         best_dist = 0;
         for (int i = 0; i < int'(path_len); i++) begin
            dx = longint'(qx) - longint'(path_x[i]);
            dy = longint'(qy) - longint'(path_y[i]);
            sq_dist = dx * dx + dy * dy;
            if (i == 0 || sq_dist < best_dist) begin
               best_dist = sq_dist;
               best = INDEX_W'(i);
            end
         end
         return best;
      endfunction

      // Progress over the window in Q.16; a backward step scores above one.
      function score_result_type score_trajectory(logic signed [COORD_BITS-1:0] fx,
                                                  logic signed [COORD_BITS-1:0] fy,
                                                  logic signed [COORD_BITS-1:0] lx,
                                                  logic signed [COORD_BITS-1:0] ly);
         score_result_type r;
         longint step;
         longint quot;
         r.start_index = nearest_point(fx, fy);
         r.end_index = nearest_point(lx, ly);
         step = longint'(r.end_index) - longint'(r.start_index);
         quot = 0;
         if (window_len != 0 && step <= longint'(window_len)) begin
            quot = ((longint'(window_len) - step) << FRAC_BITS) / longint'(window_len);
            if (quot > SCORE_MAX) begin
               quot = SCORE_MAX;
            end
         end
         r.score = SCORE_W'(quot);
         r.index_step = INDEX_W'(step);
         return r;
      endfunction

      // Applies one accepted request to the path and queues any score it owes.
      function void take_request(logic [OP_W-1:0] op,
                                 logic signed [COORD_BITS-1:0] fx,
                                 logic signed [COORD_BITS-1:0] fy,
                                 logic signed [COORD_BITS-1:0] lx,
                                 logic signed [COORD_BITS-1:0] ly);
         case (op)
            OP_CLEAR: begin
               path_len = 0;
            end
            OP_APPEND: begin
               if (path_len < MAX_PATH_POINTS) begin
                  path_x[path_len] = fx;
                  path_y[path_len] = fy;
                  path_len++;
               end
            end
            OP_SCORE: begin
               pending_scores.push_back(score_trajectory(fx, fy, lx, ly));
            end
            default: begin
            end
         endcase
      endfunction

      function void compare_field(string name, logic signed [31:0] want,
                                  logic signed [31:0] got);
         if (got !== want) begin
            mismatches++;
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
         end
      endfunction

      // Checks one score transfer against the oldest score still owed.
      function void check_score(score_result_type got);
         score_result_type want;
         if (pending_scores.size() == 0) begin
            mismatches++;
            $display("%0t: score transfer with none expected: expected nothing, actual %p",
                     $time, got);
            return;
         end
         want = pending_scores.pop_front();
         compare_field("score", want.score, got.score);
         compare_field("start_index", want.start_index, got.start_index);
         compare_field("end_index", want.end_index, got.end_index);
         compare_field("index_step", want.index_step, got.index_step);
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;
   logic psel;
   logic penable;
   logic pwrite;
   logic [PADDR_W-1:0] paddr;
   logic [DATA_W-1:0] pwdata;
   logic [DATA_W-1:0] prdata;
   logic pready;

   pps_req_if req_ch ();
   pps_rsp_if rsp_ch ();

   progress_tracker tracker;
   int burst_left = 0;
   int quiet_cycles = 0;

   path_progress_scorer_top dut (
      .clock   (clock),
      .reset   (reset),
      .req     (req_ch),
      .rsp     (rsp_ch),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Result receiver: switches between always ready, coin-flip ready and long
   // runs of stall, so stalls land on every phase of the block's work.
   initial begin
      ready_mode_type ready_mode;
      int mode_left;
      int run_left;
      ready_mode = RDY_ALWAYS;
      mode_left = 0;
      run_left = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (mode_left == 0) begin
            ready_mode = ready_mode_type'($urandom_range(0, 2));
            mode_left = $urandom_range(40, 400);
         end else begin
            mode_left--;
         end
         case (ready_mode)
            RDY_ALWAYS: rsp_ch.ready <= 1'b1;
            RDY_COIN: rsp_ch.ready <= 1'($urandom_range(0, 1));
            default: begin
               if (run_left == 0) begin
                  rsp_ch.ready <= ~rsp_ch.ready;
                  run_left = $urandom_range(1, 40);
               end else begin
                  run_left--;
               end
            end
         endcase
      end
   end

   // Result monitor.
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         tracker.check_score('{rsp_ch.score, rsp_ch.start_index, rsp_ch.end_index,
                               rsp_ch.index_step});
      end
   end

   // Watchdog: ends the run after too many cycles without any transfer.
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || psel) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= IDLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // Sends one request and notes it at the edge of its transfer; bursts of
   // back-to-back requests alternate with random gaps.
   task automatic send(input logic [OP_W-1:0] op,
                       input logic signed [COORD_BITS-1:0] fx,
                       input logic signed [COORD_BITS-1:0] fy,
                       input logic signed [COORD_BITS-1:0] lx,
                       input logic signed [COORD_BITS-1:0] ly);
      req_ch.valid <= 1'b1;
      req_ch.op <= op;
      req_ch.first_x <= fx;
      req_ch.first_y <= fy;
      req_ch.last_x <= lx;
      req_ch.last_y <= ly;
      do @(posedge clock); while (!req_ch.ready);
      tracker.take_request(op, fx, fy, lx, ly);
      @(negedge clock);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(negedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                  : $urandom_range(0, 10);
      end
   endtask

   // Holds the sender off until every owed score has come back.
   task automatic wait_for_scores();
      req_ch.valid <= 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   // Leaves the block idle: no score owed and any clear or append finished.
   task automatic drain();
      wait_for_scores();
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Writes the window register, then reads it back.
   task automatic write_window(input logic [WINDOW_W-1:0] value);
      logic [DATA_W-1:0] readback;
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= WINDOW_ADDR;
      pwdata <= DATA_W'(value);
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      tracker.set_window(value);
      @(negedge clock);
      pwrite <= 1'b0;
      penable <= 1'b0;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      readback = prdata;
      if (readback !== DATA_W'(value)) begin
         tracker.mismatches++;
         $display("%0t: window readback mismatch: expected %0d, actual %0d",
                  $time, value, readback);
      end
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
   endtask

   // Mostly small coordinates so that ties are common, then full-range values
   // and the extremes.
   function automatic logic signed [COORD_BITS-1:0] rand_coord();
      int pick;
      pick = $urandom_range(0, 19);
      if (pick < 10) begin
         return COORD_BITS'(int'($urandom_range(0, 8)) - 4);
      end else if (pick < 17) begin
         return COORD_BITS'($urandom);
      end
      case ($urandom_range(0, 3))
         0: return COORD_MIN;
         1: return COORD_MAX;
         2: return '0;
         default: return '1;
      endcase
   endfunction

   // Random traffic: runs of appends followed by scores, with clears that keep
   // the path short, plus unused op codes and pauses until all scores are back.
   task automatic random_phase(input int item_count);
      int done;
      int pick;
      int k;
      logic [OP_W-1:0] op;
      logic signed [COORD_BITS-1:0] fx;
      logic signed [COORD_BITS-1:0] fy;
      logic signed [COORD_BITS-1:0] lx;
      logic signed [COORD_BITS-1:0] ly;
      done = 0;
      while (done < item_count) begin
         pick = $urandom_range(0, 99);
         if (tracker.path_len >= 40 && pick < 30) begin
            op = OP_CLEAR;
         end else if (pick < 5) begin
            op = OP_CLEAR;
         end else if (pick < 9) begin
            op = OP_UNUSED;
         end else if (pick < 55) begin
            op = OP_APPEND;
         end else begin
            op = OP_SCORE;
         end
         fx = rand_coord();
         fy = rand_coord();
         lx = rand_coord();
         ly = rand_coord();
         if (op == OP_SCORE && tracker.path_len > 0 && $urandom_range(0, 3) == 0) begin
            k = $urandom_range(0, tracker.path_len - 1);
            fx = tracker.path_x[k];
            fy = tracker.path_y[k];
            k = $urandom_range(k, tracker.path_len - 1);
            lx = tracker.path_x[k];
            ly = tracker.path_y[k];
         end
         send(op, fx, fy, lx, ly);
         if (op != OP_UNUSED) begin
            done++;
         end
         if ($urandom_range(0, 39) == 0) begin
            wait_for_scores();
         end
      end
   endtask

   initial begin
      logic [WINDOW_W-1:0] phase_window [5];
      tracker = new();
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.op = OP_CLEAR;
      req_ch.first_x = '0;
      req_ch.first_y = '0;
      req_ch.last_x = '0;
      req_ch.last_y = '0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed, reset window: empty path, unused op code, extreme points,
      // duplicate points, forward and backward steps.
      send(OP_SCORE, 0, 0, 0, 0);
      send(OP_UNUSED, COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN);
      send(OP_APPEND, COORD_MIN, COORD_MIN, 0, 0);
      send(OP_APPEND, COORD_MAX, COORD_MAX, 0, 0);
      send(OP_APPEND, 0, 0, 0, 0);
      send(OP_APPEND, COORD_MAX, COORD_MIN, 0, 0);
      send(OP_APPEND, COORD_MIN, COORD_MAX, 0, 0);
      send(OP_APPEND, 0, 0, 0, 0);
      send(OP_APPEND, 5, 5, 0, 0);
      send(OP_SCORE, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN);
      send(OP_SCORE, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX);
      send(OP_SCORE, 0, 0, 0, 0);
      send(OP_SCORE, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX);
      send(OP_CLEAR, 0, 0, 0, 0);
      send(OP_SCORE, 1, 1, -1, -1);
      drain();

      // Window of one: steps beyond, at and below the window, and equal
      // distances to two points.
      write_window(1);
      send(OP_APPEND, 0, 0, 0, 0);
      send(OP_APPEND, 10, 0, 0, 0);
      send(OP_APPEND, 20, 0, 0, 0);
      send(OP_SCORE, 0, 0, 20, 0);
      send(OP_SCORE, 5, 0, 15, 0);
      send(OP_SCORE, 10, 0, 10, 0);
      send(OP_SCORE, 20, 0, 0, 0);
      drain();

      // Zero window, then the widest window.
      write_window(0);
      send(OP_SCORE, 20, 0, 0, 0);
      drain();
      write_window({WINDOW_W{1'b1}});
      send(OP_SCORE, 20, 0, 0, 0);
      drain();

      // Random phases over several windows.
      phase_window[0] = 1;
      phase_window[1] = 6;
      phase_window[2] = WINDOW_W'($urandom_range(2, 65534));
      phase_window[3] = {WINDOW_W{1'b1}};
      phase_window[4] = 0;
      for (int p = 0; p < 5; p++) begin
         write_window(phase_window[p]);
         random_phase(50);
         drain();
      end

      if (tracker.mismatches == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end
endmodule
